### rtl/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg: shared constants for triangle setup
// Field widths and fixed-point scales of the barycentric and normal outputs.
// ----------------------------------------------------------------------------
package tsb_pkg;

    // default coordinate width (signed, 8 fraction bits)
    localparam int COORD_BITS_DEF = 16;

    // barycentric weights, signed Q4.16
    localparam int BARY_W    = 20;
    localparam int BARY_FRAC = 16;

    // unit normal components, signed Q1.15
    localparam int NORM_W    = 16;
    localparam int NORM_FRAC = 15;

    // triangle area, unsigned Q20.16
    localparam int AREA_W    = 36;

endpackage

### rtl/tsb_div.sv
// ----------------------------------------------------------------------------
// tsb_div: pipelined restoring divider
// Unsigned floor(num / den), one quotient bit per stage, with an overflow
// flag set when the quotient does not fit in QUO_W bits. An entry stage runs the overflow check.
// ----------------------------------------------------------------------------
module tsb_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 20,
    parameter int QUO_W = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_cap
);

    localparam int CW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

    logic [CW-1:0]    r_rem [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0] r_quo [QUO_W+1];
    logic             r_cap [QUO_W+1];

    // entry stage: overflow check against den shifted past the top bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_cap[0] <= (CW'(i_num) >= (CW'(i_den) << QUO_W));
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 1; s <= QUO_W; s++) begin : g_step
        localparam int BIT = QUO_W - s;
        logic [CW-1:0] w_trial;
        logic          w_take;

        assign w_trial = CW'(r_den[s-1]) << BIT;
        assign w_take  = (r_rem[s-1] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_take ? (r_rem[s-1] - w_trial) : r_rem[s-1];
                r_quo[s] <= r_quo[s-1] | (QUO_W'(w_take) << BIT);
                r_den[s] <= r_den[s-1];
                r_cap[s] <= r_cap[s-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_cap = r_cap[QUO_W];

endmodule

### rtl/triangle_setup_barycentric.sv
// ----------------------------------------------------------------------------
// triangle_setup_barycentric: triangle normal, area and barycentric weights
// Per beat: vertices A, B, C and a query point in, weights, unit normal,
// area and a degenerate flag out.
// ----------------------------------------------------------------------------
// Usage
//   Input beat: i_valid with the twelve coordinates; taken when o_stall is low.
//   Output beat: o_valid with the result fields; taken when i_stall is low.
//   One beat can enter every cycle while o_stall is low; beats leave in
//   order, one per cycle while i_stall is low. The pipeline depth is set
//   by the square-root chain (one root bit per stage, RW = 2*COORD_BITS + 3
//   root bits) followed by the normal dividers (one quotient bit per
//   stage); the weight dividers run beside the square root.
//   Throughput is one beat per cycle while the receiver does not stall.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_stall rises in the same cycle; nothing is lost or repeated.
//   Reset (i_rst_n low, synchronous) empties the pipeline; there is no
//   other state. A zero-area triangle gives degenerate = 1 and all other
//   result fields zero.
// ----------------------------------------------------------------------------
module triangle_setup_barycentric #(
    parameter int COORD_BITS = tsb_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [COORD_BITS-1:0]          i_a_x,
    input  logic signed [COORD_BITS-1:0]          i_a_y,
    input  logic signed [COORD_BITS-1:0]          i_a_z,
    input  logic signed [COORD_BITS-1:0]          i_b_x,
    input  logic signed [COORD_BITS-1:0]          i_b_y,
    input  logic signed [COORD_BITS-1:0]          i_b_z,
    input  logic signed [COORD_BITS-1:0]          i_c_x,
    input  logic signed [COORD_BITS-1:0]          i_c_y,
    input  logic signed [COORD_BITS-1:0]          i_c_z,
    input  logic signed [COORD_BITS-1:0]          i_point_x,
    input  logic signed [COORD_BITS-1:0]          i_point_y,
    input  logic signed [COORD_BITS-1:0]          i_point_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [tsb_pkg::BARY_W-1:0]     o_alpha,
    output logic signed [tsb_pkg::BARY_W-1:0]     o_beta,
    output logic signed [tsb_pkg::BARY_W-1:0]     o_gamma,
    output logic signed [tsb_pkg::NORM_W-1:0]     o_normal_x,
    output logic signed [tsb_pkg::NORM_W-1:0]     o_normal_y,
    output logic signed [tsb_pkg::NORM_W-1:0]     o_normal_z,
    output logic        [tsb_pkg::AREA_W-1:0]     o_area,
    output logic                                  o_degenerate
);

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;            // edge vector component
    localparam int XW  = 2 * DW + 1;        // cross product component
    localparam int MW  = 2 * XW;            // product of two cross components
    localparam int PW  = 2 * XW + 2;        // dot product sum
    localparam int QW  = 2 * XW;            // squared length, unsigned
    localparam int RW  = XW;                // root of squared length
    localparam int SW  = 2 * RW + 1;        // square-root remainder

    localparam int BQ  = tsb_pkg::BARY_W;
    localparam int BSH = tsb_pkg::BARY_FRAC + 1;
    localparam int BNW = PW + BSH + 1;
    localparam int BDL = BQ + 1;

    localparam int NQ  = tsb_pkg::NORM_W;
    localparam int NSH = tsb_pkg::NORM_FRAC + 1;
    localparam int NNW = XW + NSH + 1;
    localparam int NDL = NQ + 1;

    localparam int AW  = tsb_pkg::AREA_W;
    localparam int LS  = RW + NDL;          // side band after stage 5
    localparam int BDY = LS - BDL;          // weight realignment

    localparam logic [BQ-1:0] B_HI  = {1'b0, {(BQ-1){1'b1}}};
    localparam logic [BQ-1:0] B_MIN = {1'b1, {(BQ-1){1'b0}}};
    localparam logic [NQ-1:0] N_HI  = {1'b0, {(NQ-1){1'b1}}};
    localparam logic [NQ-1:0] N_MIN = {1'b1, {(NQ-1){1'b0}}};

    typedef struct packed {
        logic       deg;
        logic [2:0] sgn;
    } t_side;

    typedef struct packed {
        logic [RW-1:0] root;
        logic [2:0]    sgn;
    } t_post;

    typedef struct packed {
        logic [2:0][BQ-1:0] quo;
        logic [2:0]         cap;
    } t_bary;

    // global advance: hold everything while a result waits under stall
    logic w_en;
    logic r_ov;

    assign w_en    = !r_ov || !i_stall;
    assign o_stall = !w_en;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: edge vectors for the four cross products
    logic signed [DW-1:0] r1_u [4][3];
    logic signed [DW-1:0] r1_v [4][3];
    logic signed [DW-1:0] w_a [3];
    logic signed [DW-1:0] w_b [3];
    logic signed [DW-1:0] w_c [3];
    logic signed [DW-1:0] w_x [3];

    assign w_a[0] = DW'(i_a_x);
    assign w_a[1] = DW'(i_a_y);
    assign w_a[2] = DW'(i_a_z);
    assign w_b[0] = DW'(i_b_x);
    assign w_b[1] = DW'(i_b_y);
    assign w_b[2] = DW'(i_b_z);
    assign w_c[0] = DW'(i_c_x);
    assign w_c[1] = DW'(i_c_y);
    assign w_c[2] = DW'(i_c_z);
    assign w_x[0] = DW'(i_point_x);
    assign w_x[1] = DW'(i_point_y);
    assign w_x[2] = DW'(i_point_z);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r1_u[0][j] <= w_b[j] - w_a[j];  // normal: ab x ac
                r1_v[0][j] <= w_c[j] - w_a[j];
                r1_u[1][j] <= w_c[j] - w_b[j];  // alpha: bc x bx
                r1_v[1][j] <= w_x[j] - w_b[j];
                r1_u[2][j] <= w_x[j] - w_a[j];  // beta: ax x ac
                r1_v[2][j] <= w_c[j] - w_a[j];
                r1_u[3][j] <= w_b[j] - w_a[j];  // gamma: ab x ax
                r1_v[3][j] <= w_x[j] - w_a[j];
            end
        end
    end

    // stage 2: cross-product partial products
    logic signed [2*DW-1:0] r2_p [4][6];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r2_p[k][0] <= r1_u[k][1] * r1_v[k][2];
                r2_p[k][1] <= r1_u[k][2] * r1_v[k][1];
                r2_p[k][2] <= r1_u[k][2] * r1_v[k][0];
                r2_p[k][3] <= r1_u[k][0] * r1_v[k][2];
                r2_p[k][4] <= r1_u[k][0] * r1_v[k][1];
                r2_p[k][5] <= r1_u[k][1] * r1_v[k][0];
            end
        end
    end

    // stage 3: cross products
    logic signed [XW-1:0] r3_cr [4][3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_cr[k][j] <= XW'(r2_p[k][2*j]) - XW'(r2_p[k][2*j+1]);
                end
            end
        end
    end

    // stage 4: products with the area vector
    logic signed [MW-1:0] r4_m [4][3];
    logic signed [XW-1:0] r4_n [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_m[k][j] <= r3_cr[0][j] * r3_cr[k][j];
                end
            end
            for (int j = 0; j < 3; j++) begin
                r4_n[j] <= r3_cr[0][j];
            end
        end
    end

    // stage 5: squared length and the three weight numerators
    logic signed [PW-1:0] r5_s [4];
    logic signed [XW-1:0] r5_n [3];
    logic [QW-1:0]        w_q;
    logic                 w_deg;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                r5_s[k] <= PW'(r4_m[k][0]) + PW'(r4_m[k][1]) + PW'(r4_m[k][2]);
            end
            for (int j = 0; j < 3; j++) begin
                r5_n[j] <= r4_n[j];
            end
        end
    end

    assign w_q   = r5_s[0][QW-1:0];
    assign w_deg = (w_q == '0);

    // weight dividers: round(|d| * 2^16 / q) as floor((|d|*2^17 + q) / 2q)
    logic [BQ-1:0] w_bq [3];
    logic          w_bc [3];
    logic [2:0]    w_bsgn;

    for (genvar k = 0; k < 3; k++) begin : g_bdiv
        logic [PW-1:0]  w_mag;
        logic [BNW-1:0] w_num;

        assign w_bsgn[k] = r5_s[k+1][PW-1];
        assign w_mag     = w_bsgn[k] ? unsigned'(-r5_s[k+1]) : unsigned'(r5_s[k+1]);
        assign w_num     = (BNW'(w_mag) << BSH) + BNW'(w_q);

        tsb_div #(
            .NUM_W (BNW),
            .DEN_W (QW + 1),
            .QUO_W (BQ)
        ) u_bdiv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num),
            .i_den ({w_q, 1'b0}),
            .o_quo (w_bq[k]),
            .o_cap (w_bc[k])
        );
    end

    // square root, one result bit per stage
    logic [SW-1:0] r_sq_rem  [RW+1];
    logic [RW-1:0] r_sq_root [RW+1];

    for (genvar j = 1; j <= RW; j++) begin : g_sqrt
        localparam int BIT = RW - j;
        logic [SW-1:0] w_rem_in;
        logic [RW-1:0] w_root_in;
        logic [SW-1:0] w_trial;
        logic          w_take;

        if (j == 1) begin : g_first
            assign w_rem_in  = SW'(w_q);
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_sq_rem[j-1];
            assign w_root_in = r_sq_root[j-1];
        end

        assign w_trial = (SW'(w_root_in) << (BIT + 1)) | (SW'(1) << (2 * BIT));
        assign w_take  = (w_rem_in >= w_trial);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[j]  <= w_take ? (w_rem_in - w_trial) : w_rem_in;
                r_sq_root[j] <= w_root_in | (RW'(w_take) << BIT);
            end
        end
    end

    // area vector delayed alongside the square root
    logic [2:0][XW-1:0] r_nd [RW];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nd[0] <= {r5_n[2], r5_n[1], r5_n[0]};
            for (int d = 1; d < RW; d++) begin
                r_nd[d] <= r_nd[d-1];
            end
        end
    end

    // normal dividers: round(|n| * 2^15 / len) as floor((|n|*2^16 + len) / 2len)
    logic [NQ-1:0] w_nq [3];
    logic          w_nc [3];
    logic [2:0]    w_nsgn;
    logic [RW-1:0] w_len;

    assign w_len = r_sq_root[RW];

    for (genvar k = 0; k < 3; k++) begin : g_ndiv
        logic signed [XW-1:0] w_n;
        logic [XW-1:0]        w_mag;
        logic [NNW-1:0]       w_num;

        assign w_n       = signed'(r_nd[RW-1][k]);
        assign w_nsgn[k] = w_n[XW-1];
        assign w_mag     = w_nsgn[k] ? unsigned'(-w_n) : unsigned'(w_n);
        assign w_num     = (NNW'(w_mag) << NSH) + NNW'(w_len);

        tsb_div #(
            .NUM_W (NNW),
            .DEN_W (RW + 1),
            .QUO_W (NQ)
        ) u_ndiv (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num),
            .i_den ({w_len, 1'b0}),
            .o_quo (w_nq[k]),
            .o_cap (w_nc[k])
        );
    end

    // side band: valid, degenerate flag and weight signs
    logic  r_vd [LS];
    t_side r_sd [LS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            for (int d = 0; d < LS; d++) begin
                r_vd[d] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= r_v4;
            r_vd[0] <= r_v5;
            for (int d = 1; d < LS; d++) begin
                r_vd[d] <= r_vd[d-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= '{deg: w_deg, sgn: w_bsgn};
            for (int d = 1; d < LS; d++) begin
                r_sd[d] <= r_sd[d-1];
            end
        end
    end

    // root and normal signs held over the normal dividers
    t_post r_pd [NDL];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd[0] <= '{root: w_len, sgn: w_nsgn};
            for (int d = 1; d < NDL; d++) begin
                r_pd[d] <= r_pd[d-1];
            end
        end
    end

    // weight quotients held until the normals finish
    t_bary r_bd [BDY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bd[0] <= '{quo: {w_bq[2], w_bq[1], w_bq[0]},
                         cap: {w_bc[2], w_bc[1], w_bc[0]}};
            for (int d = 1; d < BDY; d++) begin
                r_bd[d] <= r_bd[d-1];
            end
        end
    end

    // final rounding sign, saturation and degenerate masking
    logic [BQ-1:0]    w_bo [3];
    logic [NQ-1:0]    w_no [3];
    logic [AW-1:0]    w_area;
    logic [RW+AW-1:0] w_half;
    t_side            w_side;
    t_post            w_post;
    t_bary            w_bary;

    assign w_side = r_sd[LS-1];
    assign w_post = r_pd[NDL-1];
    assign w_bary = r_bd[BDY-1];
    assign w_half = (RW+AW)'(w_post.root) >> 1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!w_side.sgn[k]) begin
                w_bo[k] = (w_bary.cap[k] || w_bary.quo[k] > B_HI) ? B_HI : w_bary.quo[k];
            end else begin
                w_bo[k] = (w_bary.cap[k] || w_bary.quo[k] > B_MIN) ? B_MIN
                                                                   : -w_bary.quo[k];
            end
            if (!w_post.sgn[k]) begin
                w_no[k] = (w_nc[k] || w_nq[k] > N_HI) ? N_HI : w_nq[k];
            end else begin
                w_no[k] = (w_nc[k] || w_nq[k] > N_MIN) ? N_MIN : -w_nq[k];
            end
            if (w_side.deg) begin
                w_bo[k] = '0;
                w_no[k] = '0;
            end
        end
        if (w_half > (RW+AW)'({AW{1'b1}})) begin
            w_area = {AW{1'b1}};
        end else begin
            w_area = w_half[AW-1:0];
        end
        if (w_side.deg) begin
            w_area = '0;
        end
    end

    // output register
    logic [BQ-1:0] r_o_bary [3];
    logic [NQ-1:0] r_o_norm [3];
    logic [AW-1:0] r_o_area;
    logic          r_o_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_vd[LS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_o_bary[k] <= w_bo[k];
                r_o_norm[k] <= w_no[k];
            end
            r_o_area <= w_area;
            r_o_deg  <= w_side.deg;
        end
    end

    assign o_valid      = r_ov;
    assign o_alpha      = signed'(r_o_bary[0]);
    assign o_beta       = signed'(r_o_bary[1]);
    assign o_gamma      = signed'(r_o_bary[2]);
    assign o_normal_x   = signed'(r_o_norm[0]);
    assign o_normal_y   = signed'(r_o_norm[1]);
    assign o_normal_z   = signed'(r_o_norm[2]);
    assign o_area       = r_o_area;
    assign o_degenerate = r_o_deg;

endmodule

### verif/triangle_setup_checker.sv
// ----------------------------------------------------------------------------
// triangle_setup_checker: result predictor and scoreboard for triangle setup
// Watches both channels of the block. Each input beat taken is turned into
// an expected result by exact wide-integer arithmetic; each output beat
// taken is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module triangle_setup_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    input  logic signed [15:0] i_c_x,
    input  logic signed [15:0] i_c_y,
    input  logic signed [15:0] i_c_z,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    input  logic signed [15:0] i_point_z,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [tsb_pkg::BARY_W-1:0] i_alpha,
    input  logic signed [tsb_pkg::BARY_W-1:0] i_beta,
    input  logic signed [tsb_pkg::BARY_W-1:0] i_gamma,
    input  logic signed [tsb_pkg::NORM_W-1:0] i_normal_x,
    input  logic signed [tsb_pkg::NORM_W-1:0] i_normal_y,
    input  logic signed [tsb_pkg::NORM_W-1:0] i_normal_z,
    input  logic        [tsb_pkg::AREA_W-1:0] i_area,
    input  logic               i_degenerate,
    output int                 o_fail_count,
    output int                 o_outstanding
);

    typedef logic signed [127:0] wide_t;
    typedef wide_t vec_t [3];

    typedef struct packed {
        logic signed [tsb_pkg::BARY_W-1:0] alpha;
        logic signed [tsb_pkg::BARY_W-1:0] beta;
        logic signed [tsb_pkg::BARY_W-1:0] gamma;
        logic signed [tsb_pkg::NORM_W-1:0] nx;
        logic signed [tsb_pkg::NORM_W-1:0] ny;
        logic signed [tsb_pkg::NORM_W-1:0] nz;
        logic        [tsb_pkg::AREA_W-1:0] area;
        logic                              degenerate;
    } setup_result_t;

    setup_result_t expected_results [$];

    function automatic vec_t vsub(vec_t u, vec_t v);
        vec_t r;
        for (int i = 0; i < 3; i++) r[i] = u[i] - v[i];
        return r;
    endfunction

    function automatic vec_t cross3(vec_t u, vec_t v);
        vec_t r;
        r[0] = u[1] * v[2] - u[2] * v[1];
        r[1] = u[2] * v[0] - u[0] * v[2];
        r[2] = u[0] * v[1] - u[1] * v[0];
        return r;
    endfunction

    function automatic wide_t dot(vec_t u, vec_t v);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // num * 2^scale / den, rounded half away from zero, saturated to bits
    function automatic wide_t scaled_ratio(wide_t num, wide_t den, int scale, int bits);
        wide_t mag, qv, hi, v;
        mag = (num < 0) ? -num : num;
        qv  = ((mag <<< (scale + 1)) + den) / (den <<< 1);
        hi  = (wide_t'(1) <<< (bits - 1)) - 1;
        v   = (num < 0) ? -qv : qv;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v;
    endfunction

    function automatic wide_t root_floor(wide_t q);
        wide_t r, c;
        r = 0;
        for (int i = 62; i >= 0; i--) begin
            c = r | (wide_t'(1) <<< i);
            if (c * c <= q) r = c;
        end
        return r;
    endfunction

    function automatic setup_result_t predict_setup(vec_t a, vec_t b, vec_t c, vec_t x);
        setup_result_t res;
        vec_t ab, ac, ax, bc, bx, n;
        wide_t q, len, ar;
        res = '0;
        ab = vsub(b, a);
        ac = vsub(c, a);
        ax = vsub(x, a);
        bc = vsub(c, b);
        bx = vsub(x, b);
        n  = cross3(ab, ac);
        q  = dot(n, n);
        if (q == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        res.alpha = tsb_pkg::BARY_W'(scaled_ratio(dot(n, cross3(bc, bx)), q,
                                                  tsb_pkg::BARY_FRAC, tsb_pkg::BARY_W));
        res.beta  = tsb_pkg::BARY_W'(scaled_ratio(dot(n, cross3(ax, ac)), q,
                                                  tsb_pkg::BARY_FRAC, tsb_pkg::BARY_W));
        res.gamma = tsb_pkg::BARY_W'(scaled_ratio(dot(n, cross3(ab, ax)), q,
                                                  tsb_pkg::BARY_FRAC, tsb_pkg::BARY_W));
        len = root_floor(q);
        res.nx = tsb_pkg::NORM_W'(scaled_ratio(n[0], len, tsb_pkg::NORM_FRAC,
                                               tsb_pkg::NORM_W));
        res.ny = tsb_pkg::NORM_W'(scaled_ratio(n[1], len, tsb_pkg::NORM_FRAC,
                                               tsb_pkg::NORM_W));
        res.nz = tsb_pkg::NORM_W'(scaled_ratio(n[2], len, tsb_pkg::NORM_FRAC,
                                               tsb_pkg::NORM_W));
        ar = len >>> 1;
        if (ar > (wide_t'(1) <<< tsb_pkg::AREA_W) - 1)
            ar = (wide_t'(1) <<< tsb_pkg::AREA_W) - 1;
        res.area = tsb_pkg::AREA_W'(ar);
        return res;
    endfunction

    assign o_outstanding = expected_results.size();

    // predict on every input beat, compare on every output beat
    always @(posedge i_clk) begin
        vec_t a, b, c, x;
        setup_result_t want, got;
        if (!i_rst_n) begin
            o_fail_count = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                a[0] = i_a_x;     a[1] = i_a_y;     a[2] = i_a_z;
                b[0] = i_b_x;     b[1] = i_b_y;     b[2] = i_b_z;
                c[0] = i_c_x;     c[1] = i_c_y;     c[2] = i_c_z;
                x[0] = i_point_x; x[1] = i_point_y; x[2] = i_point_z;
                expected_results.push_back(predict_setup(a, b, c, x));
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_alpha, i_beta, i_gamma, i_normal_x, i_normal_y, i_normal_z,
                        i_area, i_degenerate};
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result beat: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for triangle_setup_barycentric
// Directed triangles (extremes, degenerate, axis planes, far points) then
// random triangles, mostly well-formed, with random idle bursts on both
// sides; a separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_degenerate;
    logic signed [15:0] crd [12] = '{default: '0};
    logic signed [tsb_pkg::BARY_W-1:0] o_alpha, o_beta, o_gamma;
    logic signed [tsb_pkg::NORM_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic [tsb_pkg::AREA_W-1:0] o_area;
    int fail_count, outstanding;
    int idle_cycles = 0;
    bit quiet = 1'b0;
    int stall_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    triangle_setup_barycentric DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_a_x(crd[0]), .i_a_y(crd[1]), .i_a_z(crd[2]),
        .i_b_x(crd[3]), .i_b_y(crd[4]), .i_b_z(crd[5]),
        .i_c_x(crd[6]), .i_c_y(crd[7]), .i_c_z(crd[8]),
        .i_point_x(crd[9]), .i_point_y(crd[10]), .i_point_z(crd[11]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_alpha(o_alpha), .o_beta(o_beta), .o_gamma(o_gamma),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_area(o_area), .o_degenerate(o_degenerate)
    );

    triangle_setup_checker scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_a_x(crd[0]), .i_a_y(crd[1]), .i_a_z(crd[2]),
        .i_b_x(crd[3]), .i_b_y(crd[4]), .i_b_z(crd[5]),
        .i_c_x(crd[6]), .i_c_y(crd[7]), .i_c_z(crd[8]),
        .i_point_x(crd[9]), .i_point_y(crd[10]), .i_point_z(crd[11]),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_alpha(o_alpha), .i_beta(o_beta), .i_gamma(o_gamma),
        .i_normal_x(o_normal_x), .i_normal_y(o_normal_y), .i_normal_z(o_normal_z),
        .i_area(o_area), .i_degenerate(o_degenerate),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    // receiver stall in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 8);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no beat taken on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // one triangle beat: hold until taken, then maybe a sender gap
    task automatic send_triangle(input logic signed [15:0] v [12]);
        for (int i = 0; i < 12; i++) crd[i] <= v[i];
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic send_coords(input int ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz);
        logic signed [15:0] v [12];
        v = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz),
              16'(cx), 16'(cy), 16'(cz), 16'(px), 16'(py), 16'(pz)};
        send_triangle(v);
    endtask

    function automatic int small_coord(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    initial begin
        logic signed [15:0] v [12];
        int kind, span, k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, degenerate, axis planes, vertices, far points
        send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 0);
        send_coords(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 0);
        send_coords(0, 0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64);
        send_coords(0, 0, 0, 0, 0, 256, 256, 0, 0, 64, 0, 64);
        send_coords(0, 0, 0, 0, 256, 0, 256, 0, 0, 64, 64, 500);
        send_coords(0, 0, 0, 256, 0, 0, 512, 0, 0, 1, 2, 3);
        send_coords(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767,
                    32767, 32767, 32767);
        send_coords(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767,
                    -32768, -32768, -32768);
        send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, -32768, 0);
        send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, 32767, 100);
        send_coords(100, 200, 300, 356, 200, 300, 100, 456, 300, 100, 200, 300);
        send_coords(100, 200, 300, 356, 200, 300, 100, 456, 300, 356, 200, 300);
        send_coords(100, 200, 300, 356, 200, 300, 100, 456, 300, 100, 456, 300);
        send_coords(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
        send_coords(-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 0, 0);
        send_coords(1, 2, 3, 4, 5, 6, 7, 8, 10, 0, 0, 0);

        // hold off until every directed result is back
        i_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);

        for (int n = 0; n < 1300; n++) begin
            if (n == 1100) quiet = 1'b1;
            kind = $urandom_range(0, 9);
            span = ($urandom_range(0, 1) != 0) ? 64 : 2048;
            for (int i = 0; i < 12; i++) v[i] = 16'($urandom());
            if (kind < 6) begin
                // compact triangle with the point nearby
                for (int i = 0; i < 3; i++) begin
                    v[3 + i] = 16'(v[i] + small_coord(span));
                    v[6 + i] = 16'(v[i] + small_coord(span));
                    v[9 + i] = 16'(v[i] + small_coord(span));
                end
            end else if (kind == 6) begin
                // collinear vertices
                k = $urandom_range(0, 3);
                for (int i = 0; i < 3; i++) begin
                    v[3 + i] = 16'(v[i] + small_coord(span));
                    v[6 + i] = 16'(v[i] + k * (v[3 + i] - v[i]));
                end
            end
            send_triangle(v);
        end
        i_valid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/tsb_pkg.sv
rtl/tsb_div.sv
rtl/triangle_setup_barycentric.sv
verif/triangle_setup_checker.sv
verif/testbench.sv
